// ----- hdl/cbo_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_pkg
// Shared constants and types of the cloud block overlap cover engine.
// ----------------------------------------------------------------------------
package cbo_pkg;

  // Q1.16 fixed-point one and rounding half.
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;

  // Largest number of levels honored in one column.
  localparam int MAX_LEVELS = 256;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Divider operand widths and quotient length.
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 16;
  localparam int DIV_QW = 17;
  localparam int DIV_CW = $clog2(DIV_QW + 1);

  // One scaled level as it travels from the front to the back.
  typedef struct packed {
    logic [16:0] cov;
    logic        last;
  } cbo_word_t;

  // Result of the serial divider.
  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] quot;
  } cbo_div_res_t;

endpackage
`default_nettype wire

// ----- hdl/cloud_block_overlap_cover.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cloud_block_overlap_cover
// Overlap total cloud cover of one grid column from its resampled levels.
//
//   Channel  Direction  Handshake           Word
//   input    in         in_valid/in_ready   one level of the column
//   result   out        out_valid/out_ready total cover and block count
//   config   in         wr_en               min_cover threshold
//
// The front takes one level at a time, with no new level until the current one
// is pushed; ramp and base divisions share the bit-serial divider, which ends
// at once when a quotient overflows. The back consumes a queued word per cycle
// while idle and closes a column on its top level in its close and emit states.
// A four-word queue lets the front keep working while the result waits. Reset
// is synchronous and clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module cloud_block_overlap_cover (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [16:0]        level_cover,
  input  wire logic [7:0]         level_index,
  input  wire logic [8:0]         level_count,
  input  wire logic [16:0]        wind_effect,
  input  wire logic signed [14:0] ground_height,
  input  wire logic signed [14:0] cloud_base,
  input  wire logic               last_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [16:0]             total_cover,
  output logic [7:0]              block_count,
  input  wire logic               wr_en,
  input  wire logic [17:0]        wr_data
);
  import cbo_pkg::*;

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  cbo_word_t push_word;
  cbo_word_t pop_word;

  // Factor and scaled cover per level.
  cbo_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .level_cover   (level_cover),
    .level_index   (level_index),
    .level_count   (level_count),
    .wind_effect   (wind_effect),
    .ground_height (ground_height),
    .cloud_base    (cloud_base),
    .last_level    (last_level),
    .push          (push),
    .push_word     (push_word),
    .full          (full)
  );

  // Decoupling queue.
  cbo_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (empty)
  );

  // Block tracking and result delivery.
  cbo_back u_back (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .pop_word    (pop_word),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .total_cover (total_cover),
    .block_count (block_count)
  );

endmodule
`default_nettype wire

// ----- hdl/cbo_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_div
// Restoring divider, one quotient bit per cycle. Flags an overflow when the
// quotient does not fit in DIV_QW bits.
// ----------------------------------------------------------------------------
module cbo_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cbo_pkg::DIV_NW-1:0]  num,
  input  wire logic [cbo_pkg::DIV_DW-1:0]  den,
  output cbo_pkg::cbo_div_res_t            res
);
  import cbo_pkg::*;

  logic [DIV_DW-1:0] rem;
  logic [DIV_QW-1:0] low;
  logic [DIV_QW-1:0] quot;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              done;
  logic              ovf;

  logic [DIV_DW:0]   trial;
  logic              take;
  logic              start_ovf;

  // Trial subtraction of one step.
  assign trial     = {rem, low[DIV_QW-1]};
  assign take      = (trial >= {1'b0, den_r});
  assign start_ovf = (num[DIV_NW-1:DIV_QW] >= (DIV_NW-DIV_QW)'(den));

  // Step sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        rem   <= num[DIV_QW+DIV_DW-1:DIV_QW];
        low   <= num[DIV_QW-1:0];
        quot  <= '0;
        ovf   <= start_ovf;
        if (start_ovf) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= DIV_CW'(DIV_QW);
        end
      end else if (busy) begin
        rem  <= take ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
        low  <= {low[DIV_QW-2:0], 1'b0};
        quot <= {quot[DIV_QW-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quot = quot;

endmodule
`default_nettype wire

// ----- hdl/cbo_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_front
// Accepts one level word, forms the wind factor with its height ramp and
// cloud-base raise, scales the cover and hands the result to the queue.
// ----------------------------------------------------------------------------
module cbo_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [16:0]        level_cover,
  input  wire logic [7:0]         level_index,
  input  wire logic [8:0]         level_count,
  input  wire logic [16:0]        wind_effect,
  input  wire logic signed [14:0] ground_height,
  input  wire logic signed [14:0] cloud_base,
  input  wire logic               last_level,
  output logic                    push,
  output cbo_pkg::cbo_word_t      push_word,
  input  wire logic               full
);
  import cbo_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE, F_RAMP, F_DIV1, F_BASE, F_DIV2, F_COV, F_PUSH
  } front_state_t;

  front_state_t       state;
  logic [16:0]        c_r;
  logic [16:0]        w_r;
  logic [8:0]         n_r;
  logic [7:0]         idx_r;
  logic signed [14:0] g_r;
  logic signed [14:0] b_r;
  logic               last_r;
  logic [16:0]        f;
  logic [16:0]        cov;

  logic [8:0]          n_clamp;
  logic [8:0]          den;
  logic                ramp_flat;
  logic                ramp_top;
  logic [24:0]         ramp_prod;
  logic [DIV_NW-1:0]   ramp_num;
  logic                base_on;
  logic [14:0]         base_diff;
  logic [31:0]         base_prod;
  logic [DIV_NW-1:0]   base_num;
  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic [DIV_DW-1:0]   div_den;
  cbo_div_res_t        div_res;
  logic [17:0]         f_sum;
  logic [16:0]         f_div;
  logic [33:0]         cov_full;

  // Level count limited to the supported column height.
  assign n_clamp = (32'(level_count) > MAX_LEVELS) ? 9'(MAX_LEVELS) : level_count;

  // Ramp cases and its division operands.
  assign den       = n_r - 9'd1;
  assign ramp_flat = (n_r <= 9'd1);
  assign ramp_top  = ({1'b0, idx_r} >= den);
  assign ramp_prod = 25'(ONE_Q16 - w_r) * 25'(idx_r);
  assign ramp_num  = DIV_NW'({ramp_prod, 1'b0}) + DIV_NW'(den);

  // Raise below a positive cloud base.
  assign base_on   = (b_r > 15'sd0) && (g_r < b_r);
  assign base_diff = 15'({b_r[14], b_r} - {g_r[14], g_r});
  assign base_prod = 32'(ONE_Q16 - f) * 32'(base_diff);
  assign base_num  = DIV_NW'({base_prod, 1'b0}) + DIV_NW'(b_r);

  // Divider launch in the ramp or base state.
  always_comb begin
    div_start = 1'b0;
    div_num   = ramp_num;
    div_den   = DIV_DW'({den, 1'b0});
    if (state == F_RAMP) begin
      div_start = !ramp_flat && !ramp_top;
    end else if (state == F_BASE) begin
      div_start = base_on;
      div_num   = base_num;
      div_den   = DIV_DW'({b_r, 1'b0});
    end
  end

  cbo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // Adds a quotient to the factor, saturating at one. The ramp adds to the
  // wind value, the base raise to the current factor.
  always_comb begin
    f_sum = (state == F_DIV1) ? (18'(w_r) + 18'(div_res.quot))
                              : (18'(f) + 18'(div_res.quot));
    f_div = (div_res.ovf || f_sum > 18'(ONE_Q16)) ? ONE_Q16 : f_sum[16:0];
  end

  // Scaled cover with round to nearest.
  assign cov_full = 34'(f) * 34'(c_r) + 34'(HALF_Q16);

  // Front sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            c_r    <= (level_cover > ONE_Q16) ? ONE_Q16 : level_cover;
            w_r    <= (wind_effect > ONE_Q16) ? ONE_Q16 : wind_effect;
            n_r    <= n_clamp;
            idx_r  <= level_index;
            g_r    <= ground_height;
            b_r    <= cloud_base;
            last_r <= last_level;
            state  <= F_RAMP;
          end
        end
        F_RAMP: begin
          if (ramp_flat) begin
            f     <= w_r;
            state <= F_BASE;
          end else if (ramp_top) begin
            f     <= ONE_Q16;
            state <= F_BASE;
          end else begin
            state <= F_DIV1;
          end
        end
        F_DIV1: begin
          if (div_res.done) begin
            f     <= f_div;
            state <= F_BASE;
          end
        end
        F_BASE: begin
          state <= base_on ? F_DIV2 : F_COV;
        end
        F_DIV2: begin
          if (div_res.done) begin
            f     <= f_div;
            state <= F_COV;
          end
        end
        F_COV: begin
          cov   <= cov_full[32:16];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_ready       = (state == F_IDLE);
  assign push           = (state == F_PUSH) && !full;
  assign push_word.cov  = cov;
  assign push_word.last = last_r;

endmodule
`default_nettype wire

// ----- hdl/cbo_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_fifo
// Short first-word-fall-through queue between the front and the back.
// ----------------------------------------------------------------------------
module cbo_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  cbo_pkg::cbo_word_t push_word,
  output logic               full,
  input  wire logic          pop,
  output cbo_pkg::cbo_word_t pop_word,
  output logic               empty
);
  import cbo_pkg::*;

  cbo_word_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full     = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

endmodule
`default_nettype wire

// ----- hdl/cbo_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_back
// Tracks cloud blocks over the scaled levels of a column and, on the top
// level, delivers the overlap total cover and the block count.
// ----------------------------------------------------------------------------
module cbo_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [17:0]   wr_data,
  input  cbo_pkg::cbo_word_t pop_word,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [16:0]        total_cover,
  output logic [7:0]         block_count
);
  import cbo_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_CLOSE, B_EMIT} back_state_t;

  back_state_t        state;
  logic signed [17:0] min_cover;
  logic               in_cloud;
  logic [16:0]        block_peak;
  logic [16:0]        clear_product;
  logic [7:0]         blocks_seen;

  logic        above;
  logic [33:0] close_full;
  logic        out_free;

  // Threshold test on the scaled cover.
  assign above = ($signed({1'b0, pop_word.cov}) > min_cover);

  // Closing a block folds its complement into the product.
  assign close_full = 34'(clear_product) * 34'(ONE_Q16 - block_peak) + 34'(HALF_Q16);

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == B_IDLE) && !empty;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cover <= 18'sd6554;
    end else if (wr_en) begin
      min_cover <= wr_data;
    end
  end

  // Block tracker and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      in_cloud      <= 1'b0;
      block_peak    <= '0;
      clear_product <= ONE_Q16;
      blocks_seen   <= '0;
      out_valid     <= 1'b0;
    end else begin
      // A taken result word leaves unless a new one replaces it right away.
      if (out_valid && out_ready && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            if (above) begin
              if (!in_cloud) begin
                in_cloud   <= 1'b1;
                block_peak <= pop_word.cov;
                if (blocks_seen != 8'hFF) begin
                  blocks_seen <= blocks_seen + 8'd1;
                end
              end else if (pop_word.cov > block_peak) begin
                block_peak <= pop_word.cov;
              end
            end else if (in_cloud) begin
              clear_product <= close_full[32:16];
              in_cloud      <= 1'b0;
              block_peak    <= '0;
            end
            if (pop_word.last) begin
              state <= B_CLOSE;
            end
          end
        end
        B_CLOSE: begin
          if (in_cloud) begin
            clear_product <= close_full[32:16];
            in_cloud      <= 1'b0;
            block_peak    <= '0;
          end
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            total_cover   <= ONE_Q16 - clear_product;
            block_count   <= blocks_seen;
            in_cloud      <= 1'b0;
            block_peak    <= '0;
            clear_product <= ONE_Q16;
            blocks_seen   <= '0;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- dv/cbo_column_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbo_column_checker
// Watches the level, result and threshold ports of the cloud cover engine.
// It tracks every accepted level word and every threshold write with its own
// model of the wind factor, the block tracking and the overlap product. It
// queues the expected column results and compares each accepted result word
// with the oldest one, field by field.
// ----------------------------------------------------------------------------
module cbo_column_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [16:0]        level_cover,
  input  wire logic [7:0]         level_index,
  input  wire logic [8:0]         level_count,
  input  wire logic [16:0]        wind_effect,
  input  wire logic signed [14:0] ground_height,
  input  wire logic signed [14:0] cloud_base,
  input  wire logic               last_level,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [16:0]        total_cover,
  input  wire logic [7:0]         block_count,
  input  wire logic               wr_en,
  input  wire logic [17:0]        wr_data,
  output int                      results_due,
  output int                      fail_count
);
  import cbo_pkg::*;

  // One column result as the engine should report it.
  typedef struct packed {
    logic [16:0] total;
    logic [7:0]  blocks;
  } column_result_t;

  column_result_t     column_results_due[$];

  // Shadow of the threshold register and of the column state.
  logic signed [17:0] cloud_floor;
  logic               open_block;
  logic [16:0]        open_peak;
  logic [16:0]        clear_prod;
  logic [7:0]         block_tally;

  // Q1.16 product, rounded to nearest with halves up.
  function automatic longint unsigned q16_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  // Level cover after the wind ramp and the cloud base correction.
  function automatic logic [16:0] wind_scaled_cover(
    input logic [16:0]        cov_in,
    input logic [7:0]         idx,
    input logic [8:0]         cnt,
    input logic [16:0]        wind,
    input logic signed [14:0] gnd,
    input logic signed [14:0] base
  );
    longint unsigned c, w, n, den, f, num, bu;
    longint          g, b;
    c = (cov_in > ONE_Q16) ? ONE_Q16 : cov_in;
    w = (wind > ONE_Q16) ? ONE_Q16 : wind;
    n = (cnt > MAX_LEVELS) ? MAX_LEVELS : cnt;
    g = gnd;
    b = base;
    // Linear ramp from the wind value at the ground to one at the top.
    if (n <= 1) begin
      f = w;
    end else if (idx >= n - 1) begin
      f = ONE_Q16;
    end else begin
      den = n - 1;
      f = w + (((ONE_Q16 - w) * idx * 2) + den) / (2 * den);
    end
    if (f > ONE_Q16) f = ONE_Q16;
    // Extra lift while the ground lies below a positive cloud base.
    if (b > 0 && g < b) begin
      bu  = b;
      num = (ONE_Q16 - f) * longint'(b - g);
      f   = f + (2 * num + bu) / (2 * bu);
      if (f > ONE_Q16) f = ONE_Q16;
    end
    return 17'(q16_mul(f, c));
  endfunction

  // Fold a finished block into the product of clear fractions.
  task automatic close_open_block();
    if (open_block) begin
      clear_prod = 17'(q16_mul(clear_prod, ONE_Q16 - open_peak));
      open_block = 1'b0;
      open_peak  = '0;
    end
  endtask

  // Advance the column state by one level word.
  task automatic fold_level();
    logic [16:0]    cov;
    longint         cov_s, floor_s;
    column_result_t res;
    cov = wind_scaled_cover(level_cover, level_index, level_count, wind_effect,
                            ground_height, cloud_base);
    cov_s   = cov;
    floor_s = cloud_floor;
    if (cov_s > floor_s) begin
      if (!open_block) begin
        open_block = 1'b1;
        open_peak  = cov;
        if (block_tally != 8'd255) block_tally = block_tally + 8'd1;
      end else if (cov > open_peak) begin
        open_peak = cov;
      end
    end else begin
      close_open_block();
    end
    // The top level closes the column and yields its result.
    if (last_level) begin
      close_open_block();
      res.total  = ONE_Q16 - clear_prod;
      res.blocks = block_tally;
      column_results_due.push_back(res);
      open_block  = 1'b0;
      open_peak   = '0;
      clear_prod  = ONE_Q16;
      block_tally = '0;
    end
  endtask

  // Sample both channels and the threshold port at each rising edge.
  always @(posedge clk) begin
    column_result_t want;
    int             errs;
    if (rst) begin
      column_results_due.delete();
      cloud_floor = 18'sd6554;
      open_block  = 1'b0;
      open_peak   = '0;
      clear_prod  = ONE_Q16;
      block_tally = '0;
      fail_count  <= 0;
    end else begin
      errs = 0;
      // Result word against the oldest expectation.
      if (out_valid && out_ready) begin
        if (column_results_due.size() == 0) begin
          $error("result word with no column result due: total_cover=%0d block_count=%0d",
                 total_cover, block_count);
          errs++;
        end else begin
          want = column_results_due.pop_front();
          if (total_cover !== want.total) begin
            $error("total_cover mismatch: expected %0d, actual %0d", want.total,
                   total_cover);
            errs++;
          end
          if (block_count !== want.blocks) begin
            $error("block_count mismatch: expected %0d, actual %0d", want.blocks,
                   block_count);
            errs++;
          end
        end
      end
      if (wr_en) cloud_floor = wr_data;
      if (in_valid && in_ready) fold_level();
      fail_count <= fail_count + errs;
    end
    results_due <= column_results_due.size();
  end

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the cloud block overlap cover engine.
// Drives level words column by column with random gaps on the level side and
// random stalls on the result side, and rewrites the cloud threshold between
// phases while the engine is idle. A directed part covers clamped fractions,
// short and over-long level counts, the top of the ramp, the base correction
// cases and block count saturation; random columns follow. The checker beside
// the engine predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import cbo_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int LEVEL_TARGET = 950;
  localparam int SETTLE_WAIT  = 64;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [16:0]        level_cover;
  logic [7:0]         level_index;
  logic [8:0]         level_count;
  logic [16:0]        wind_effect;
  logic signed [14:0] ground_height;
  logic signed [14:0] cloud_base;
  logic               last_level;
  logic               out_valid;
  logic               out_ready;
  logic [16:0]        total_cover;
  logic [7:0]         block_count;
  logic               wr_en;
  logic [17:0]        wr_data;

  int                 results_due;
  int                 fail_count;
  int                 cycle_count;
  int                 levels_sent;
  logic               gaps_on;

  cloud_block_overlap_cover DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .level_cover   (level_cover),
    .level_index   (level_index),
    .level_count   (level_count),
    .wind_effect   (wind_effect),
    .ground_height (ground_height),
    .cloud_base    (cloud_base),
    .last_level    (last_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_cover   (total_cover),
    .block_count   (block_count),
    .wr_en         (wr_en),
    .wr_data       (wr_data)
  );

  cbo_column_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .level_cover   (level_cover),
    .level_index   (level_index),
    .level_count   (level_count),
    .wind_effect   (wind_effect),
    .ground_height (ground_height),
    .cloud_base    (cloud_base),
    .last_level    (last_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_cover   (total_cover),
    .block_count   (block_count),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .results_due   (results_due),
    .fail_count    (fail_count)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls unless the quiet stretch is on.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !gaps_on || ($urandom_range(99) >= 27);
    end
  end

  // Present one level word and hold it until it is taken. Entered and left
  // at a falling edge.
  task automatic send_level(input logic [16:0] cov, input logic [7:0] idx,
                            input logic [8:0] cnt, input logic [16:0] wind,
                            input logic signed [14:0] gnd,
                            input logic signed [14:0] base, input logic last);
    while (gaps_on && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    level_cover   = cov;
    level_index   = idx;
    level_count   = cnt;
    wind_effect   = wind;
    ground_height = gnd;
    cloud_base    = base;
    last_level    = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    levels_sent++;
  endtask

  // Wait for every due result, let the engine drain, then load a threshold.
  task automatic load_threshold(input int value);
    in_valid = 1'b0;
    wait (results_due == 0);
    repeat (SETTLE_WAIT) @(negedge clk);
    wr_data = 18'(value);
    wr_en   = 1'b1;
    @(negedge clk);
    wr_en   = 1'b0;
  endtask

  // Elevation in meters, mostly in the realistic range.
  function automatic logic signed [14:0] pick_height();
    int h;
    if ($urandom_range(99) < 80) h = int'($urandom_range(11000)) - 1000;
    else h = $urandom;
    return 15'(h);
  endfunction

  // One whole column of random content ending on its top level.
  task automatic random_column();
    int                 len, r;
    logic [8:0]         cnt;
    logic [16:0]        wind, cov;
    logic signed [14:0] gnd, base;
    r = $urandom_range(99);
    if (r < 70) cnt = 9'($urandom_range(24, 1));
    else if (r < 85) cnt = 9'($urandom_range(256, 25));
    else cnt = 9'($urandom_range(511));
    len = (cnt == 0) ? 1 : cnt;
    if (len > 40 || $urandom_range(99) < 15) len = $urandom_range(30, 1);
    wind = ($urandom_range(99) < 10) ? 17'($urandom) : 17'($urandom_range(65536));
    gnd  = pick_height();
    base = pick_height();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 30) cov = '0;
      else if (r < 40) cov = ONE_Q16;
      else if (r < 50) cov = 17'($urandom);
      else cov = 17'($urandom_range(65536));
      send_level(cov, 8'(i), cnt, wind, gnd, base, i == len - 1);
    end
  endtask

  // A stray level word with fully random fields.
  task automatic stray_level();
    send_level(17'($urandom), 8'($urandom), 9'($urandom), 17'($urandom),
               15'($urandom), 15'($urandom), $urandom_range(7) == 0);
  endtask

  // Main stimulus and verdict.
  initial begin
    int phase, floor_val, r;
    rst           = 1'b1;
    in_valid      = 1'b0;
    level_cover   = '0;
    level_index   = '0;
    level_count   = '0;
    wind_effect   = '0;
    ground_height = '0;
    cloud_base    = '0;
    last_level    = 1'b0;
    wr_en         = 1'b0;
    wr_data       = '0;
    levels_sent   = 0;
    gaps_on       = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed columns under the reset threshold.
    // Single level with no wind: nothing counts as cloud.
    send_level(ONE_Q16, 8'd0, 9'd1, 17'd0, 15'sd0, 15'sd0, 1'b1);
    // Zero count, fractions above one clamped to one.
    send_level(17'h1FFFF, 8'd0, 9'd0, 17'h1FFFF, 15'sd0, 15'sd0, 1'b1);
    // Ramp with base lift; two blocks, the second closed by the top level.
    send_level(17'd60000, 8'd0, 9'd4, 17'd30000, -15'sd1000, 15'sd10000, 1'b0);
    send_level(17'd100, 8'd1, 9'd4, 17'd30000, -15'sd1000, 15'sd10000, 1'b0);
    send_level(17'd40000, 8'd2, 9'd4, 17'd30000, -15'sd1000, 15'sd10000, 1'b0);
    send_level(17'd50000, 8'd3, 9'd4, 17'd30000, -15'sd1000, 15'sd10000, 1'b1);
    // Count above the level limit; ground above base and base negative.
    send_level(17'd20000, 8'd10, 9'd511, 17'd0, 15'sd10000, -15'sd1000, 1'b0);
    send_level(17'd20000, 8'd255, 9'd511, 17'd0, 15'sd5000, 15'sd3000, 1'b0);
    send_level(17'd0, 8'd200, 9'd256, 17'd1000, 15'sd0, 15'sd0, 1'b1);
    // Extreme heights and an index past the top of the ramp.
    send_level(17'd65535, 8'd0, 9'd300, 17'd0, -15'sd16384, 15'sd16383, 1'b0);
    send_level(17'd7000, 8'd5, 9'd3, 17'd65536, 15'sd16383, -15'sd16384, 1'b0);
    send_level(17'd6554, 8'd1, 9'd2, 17'd0, 15'sd0, 15'sd1, 1'b1);
    // Threshold extremes.
    load_threshold(-65536);
    send_level(17'd0, 8'd0, 9'd2, 17'd0, 15'sd0, 15'sd0, 1'b0);
    send_level(17'd0, 8'd1, 9'd2, 17'd0, 15'sd0, 15'sd0, 1'b1);
    load_threshold(65536);
    send_level(ONE_Q16, 8'd0, 9'd2, ONE_Q16, 15'sd0, 15'sd0, 1'b0);
    send_level(ONE_Q16, 8'd1, 9'd2, ONE_Q16, 15'sd0, 15'sd0, 1'b1);
    load_threshold(65535);
    send_level(ONE_Q16, 8'd0, 9'd1, ONE_Q16, 15'sd0, 15'sd0, 1'b1);

    // Long alternating column so the block count saturates.
    load_threshold(0);
    for (int i = 0; i < 520; i++) begin
      send_level((i % 2) ? 17'($urandom_range(65536, 1)) : 17'd0, 8'(i), 9'd256,
                 ONE_Q16, 15'sd0, 15'sd0, i == 519);
    end

    // Random phases, each under its own threshold.
    phase = 0;
    while (levels_sent < LEVEL_TARGET) begin
      r = $urandom_range(99);
      if (r < 10) floor_val = -65536;
      else if (r < 20) floor_val = 65536;
      else if (r < 35) floor_val = int'($urandom_range(131072)) - 65536;
      else floor_val = $urandom_range(40000);
      load_threshold(floor_val);
      gaps_on = (phase != 3);
      repeat ($urandom_range(6, 2)) begin
        if ($urandom_range(99) < 10) stray_level();
        if ($urandom_range(99) < 10) begin
          // Hold the level side until every column result is out.
          in_valid = 1'b0;
          wait (results_due == 0);
          @(negedge clk);
        end
        random_column();
      end
      phase++;
    end
    gaps_on  = 1'b1;
    in_valid = 1'b0;

    // Drain and give the verdict.
    wait (results_due == 0);
    repeat (SETTLE_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/cbo_pkg.sv
hdl/cbo_div.sv
hdl/cbo_front.sv
hdl/cbo_fifo.sv
hdl/cbo_back.sv
hdl/cloud_block_overlap_cover.sv
dv/cbo_column_checker.sv
dv/tb_top.sv
